// File: rtl/pfr_pkg.sv
package pfr_pkg;

   localparam int FormatW = 2;
   localparam int ChanW   = 8;
   localparam int SumW    = 20;
   localparam int CountW  = 2;
   localparam int ReqW    = 4 * ChanW;
   localparam int RspW    = ((6 * ChanW + CountW + 7) / 8) * 8;

   localparam logic [FormatW-1:0] FmtBgr  = 2'd0;
   localparam logic [FormatW-1:0] FmtYuy2 = 2'd1;
   localparam logic [FormatW-1:0] FmtNv12 = 2'd2;
   localparam logic [FormatW-1:0] FmtUnused = 2'd3;
   localparam logic [FormatW-1:0] FmtResetValue = FmtBgr;

   localparam logic [CountW-1:0] OnePixel  = 2'd1;
   localparam logic [CountW-1:0] TwoPixels = 2'd2;

   localparam logic signed [SumW-1:0] LumaOffset   = 20'sd16;
   localparam logic signed [SumW-1:0] ChromaOffset = 20'sd128;
   localparam logic signed [SumW-1:0] CoefY        = 20'sd298;
   localparam logic signed [SumW-1:0] CoefRv       = 20'sd409;
   localparam logic signed [SumW-1:0] CoefGu       = 20'sd100;
   localparam logic signed [SumW-1:0] CoefGv       = 20'sd208;
   localparam logic signed [SumW-1:0] CoefBu       = 20'sd516;
   localparam logic signed [SumW-1:0] RoundBias    = 20'sd128;

   typedef struct packed {
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] red;
   } rgb_type;

   function automatic logic [ChanW-1:0] clamp_channel(logic signed [SumW-1:0] sum);
      logic signed [SumW-1:0] q;
      q = sum >>> 8;
      if (q < 0)
         return '0;
      else if (q > 20'sd255)
         return '1;
      else
         return q[ChanW-1:0];
   endfunction

   function automatic rgb_type yuv_to_rgb(logic [ChanW-1:0] y, logic [ChanW-1:0] u,
                                          logic [ChanW-1:0] v);
      logic signed [SumW-1:0] c;
      logic signed [SumW-1:0] d;
      logic signed [SumW-1:0] e;
      logic signed [SumW-1:0] luma;
      rgb_type px;
      c = $signed(SumW'(y)) - LumaOffset;
      d = $signed(SumW'(u)) - ChromaOffset;
      e = $signed(SumW'(v)) - ChromaOffset;
      luma = c * CoefY + RoundBias;
      px.red   = clamp_channel(luma + e * CoefRv);
      px.green = clamp_channel(luma - d * CoefGu - e * CoefGv);
      px.blue  = clamp_channel(luma + d * CoefBu);
      return px;
   endfunction

endpackage

// File: rtl/pixel_format_to_rgb.sv
// Camera pixel converter to RGB888.
// req_ channel: one beat carries four source bytes. csr_wen/csr_wdata write
// the 2-bit format register (reset: packed BGR); user must write it only
// when idle (unenforced). BGR: bytes 0..2 B,G,R give one pixel, B/R swapped.
// YUY2: bytes Y0,U,Y1,V give two pixels (pixel_count 2).
// NV12: bytes Y,U,V give one pixel; second-pixel fields are zero.
// YUV modes use BT.601 integer math with a floor shift and 0..255 clamp.
// Format code 3 takes the beat and produces no result.
// Throughput: one beat per cycle while rsp_ is not stalled; the input
// register and the result register each hold one beat, with the conversion
// logic between them, and the result register drives rsp_.
// When rsp_tready is low the result holds; the input register still takes
// one more beat, and req_tready drops once both stages are full.
// Reset clears both stages and sets the format to packed BGR.
module pixel_format_to_rgb
   import pfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [FormatW-1:0]  csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // src_byte0, src_byte1, src_byte2, src_byte3
   input  logic [ReqW-1:0]     req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // red_first, green_first, blue_first, red_second, green_second,
   // blue_second, pixel_count, zero fill
   output logic [RspW-1:0]     rsp_tdata
);

   logic [FormatW-1:0] format_ff;
   logic               in_valid_ff;
   logic [ReqW-1:0]    in_data_ff;
   logic               in_valid_in;
   logic               out_valid_ff;
   logic [RspW-1:0]    out_data_ff;
   logic [RspW-1:0]    out_data_in;
   logic               out_advance;
   logic               in_advance;
   rgb_type            first_px;
   rgb_type            second_px;
   rgb_type            bgr_px;
   logic [ChanW-1:0]   b0;
   logic [ChanW-1:0]   b1;
   logic [ChanW-1:0]   b2;
   logic [ChanW-1:0]   b3;

   assign out_advance = !out_valid_ff || rsp_tready;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_tready  = in_advance;
   assign in_valid_in = req_tvalid && (format_ff != FmtUnused);

   assign b0 = in_data_ff[ChanW-1:0];
   assign b1 = in_data_ff[2*ChanW-1:ChanW];
   assign b2 = in_data_ff[3*ChanW-1:2*ChanW];
   assign b3 = in_data_ff[4*ChanW-1:3*ChanW];

   always_comb begin
      bgr_px.red   = b2;
      bgr_px.green = b1;
      bgr_px.blue  = b0;
      first_px     = '0;
      second_px    = '0;
      out_data_in  = '0;
      unique case (format_ff)
         FmtBgr: begin
            first_px = bgr_px;
            out_data_in[6*ChanW +: CountW] = OnePixel;
         end
         FmtYuy2: begin
            first_px  = yuv_to_rgb(b0, b1, b3);
            second_px = yuv_to_rgb(b2, b1, b3);
            out_data_in[6*ChanW +: CountW] = TwoPixels;
         end
         FmtNv12: begin
            first_px = yuv_to_rgb(b0, b1, b2);
            out_data_in[6*ChanW +: CountW] = OnePixel;
         end
         default: begin
            first_px = '0;
         end
      endcase
      out_data_in[0*ChanW +: ChanW] = first_px.red;
      out_data_in[1*ChanW +: ChanW] = first_px.green;
      out_data_in[2*ChanW +: ChanW] = first_px.blue;
      out_data_in[3*ChanW +: ChanW] = second_px.red;
      out_data_in[4*ChanW +: ChanW] = second_px.green;
      out_data_in[5*ChanW +: ChanW] = second_px.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FmtResetValue;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            format_ff <= csr_wdata;
         end
         if (in_advance) begin
            in_valid_ff <= in_valid_in;
         end
         if (out_advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
      if (out_advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
